// File: rtl/core/sc2a_pkg.sv
// ---------------------------------------------------------------------------
// sc2a_pkg: shared types and constants of the scan code to ASCII queue
// Word formats, status codes, queue sizing and the set-1 key maps.
// ---------------------------------------------------------------------------
package sc2a_pkg;

  // Queue sizing (one slot always left empty)
  localparam int QSLOTS = 512;
  localparam int PTR_W  = $clog2(QSLOTS);

  // Opcodes
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_QUEUED  = 3'd1;
  localparam logic [2:0] ST_DROPPED = 3'd2;
  localparam logic [2:0] ST_READ    = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  // Scan codes of interest
  localparam logic [7:0] SC_PREFIX     = 8'hE0;
  localparam logic [7:0] SC_LSHIFT     = 8'h2A;
  localparam logic [7:0] SC_RSHIFT     = 8'h36;
  localparam logic [7:0] SC_LSHIFT_REL = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_REL = 8'hB6;
  localparam logic [7:0] SC_CAPS       = 8'h3A;
  localparam logic [7:0] MAP_LEN       = 8'd58;
  localparam logic [6:0] CASE_OFFSET   = 7'd32;

  typedef struct packed {
    logic       opcode;
    logic [7:0] scan_byte;
  } req_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] char_code;
  } rsp_word_t;

  // Queue requests from the top level
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [6:0] wr_char;
  } q_ctrl_t;

  // Queue state seen by the top level
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Unshifted key map
  function automatic logic [6:0] plain_map(input logic [5:0] idx);
    logic [6:0] c;
    unique case (idx)
      6'd2:  c = 7'h31;
      6'd3:  c = 7'h32;
      6'd4:  c = 7'h33;
      6'd5:  c = 7'h34;
      6'd6:  c = 7'h35;
      6'd7:  c = 7'h36;
      6'd8:  c = 7'h37;
      6'd9:  c = 7'h38;
      6'd10: c = 7'h39;
      6'd11: c = 7'h30;
      6'd12: c = 7'h2D;
      6'd13: c = 7'h3D;
      6'd14: c = 7'h08;
      6'd16: c = 7'h71;
      6'd17: c = 7'h77;
      6'd18: c = 7'h65;
      6'd19: c = 7'h72;
      6'd20: c = 7'h74;
      6'd21: c = 7'h79;
      6'd22: c = 7'h75;
      6'd23: c = 7'h69;
      6'd24: c = 7'h6F;
      6'd25: c = 7'h70;
      6'd26: c = 7'h5B;
      6'd27: c = 7'h5D;
      6'd28: c = 7'h0A;
      6'd30: c = 7'h61;
      6'd31: c = 7'h73;
      6'd32: c = 7'h64;
      6'd33: c = 7'h66;
      6'd34: c = 7'h67;
      6'd35: c = 7'h68;
      6'd36: c = 7'h6A;
      6'd37: c = 7'h6B;
      6'd38: c = 7'h6C;
      6'd39: c = 7'h3B;
      6'd40: c = 7'h27;
      6'd41: c = 7'h60;
      6'd43: c = 7'h5C;
      6'd44: c = 7'h7A;
      6'd45: c = 7'h78;
      6'd46: c = 7'h63;
      6'd47: c = 7'h76;
      6'd48: c = 7'h62;
      6'd49: c = 7'h6E;
      6'd50: c = 7'h6D;
      6'd51: c = 7'h2C;
      6'd52: c = 7'h2E;
      6'd53: c = 7'h2F;
      6'd55: c = 7'h2A;
      6'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // Shifted key map
  function automatic logic [6:0] shifted_map(input logic [5:0] idx);
    logic [6:0] c;
    unique case (idx)
      6'd1:  c = 7'h01;
      6'd2:  c = 7'h21;
      6'd3:  c = 7'h40;
      6'd4:  c = 7'h23;
      6'd5:  c = 7'h24;
      6'd6:  c = 7'h25;
      6'd7:  c = 7'h5E;
      6'd8:  c = 7'h26;
      6'd9:  c = 7'h2A;
      6'd10: c = 7'h28;
      6'd11: c = 7'h29;
      6'd12: c = 7'h5F;
      6'd13: c = 7'h2B;
      6'd14: c = 7'h08;
      6'd15: c = 7'h09;
      6'd16: c = 7'h51;
      6'd17: c = 7'h57;
      6'd18: c = 7'h45;
      6'd19: c = 7'h52;
      6'd20: c = 7'h54;
      6'd21: c = 7'h59;
      6'd22: c = 7'h55;
      6'd23: c = 7'h49;
      6'd24: c = 7'h4F;
      6'd25: c = 7'h50;
      6'd26: c = 7'h7B;
      6'd27: c = 7'h7D;
      6'd28: c = 7'h0A;
      6'd30: c = 7'h41;
      6'd31: c = 7'h53;
      6'd32: c = 7'h44;
      6'd33: c = 7'h46;
      6'd34: c = 7'h47;
      6'd35: c = 7'h48;
      6'd36: c = 7'h4A;
      6'd37: c = 7'h4B;
      6'd38: c = 7'h4C;
      6'd39: c = 7'h3A;
      6'd40: c = 7'h22;
      6'd41: c = 7'h7E;
      6'd43: c = 7'h7C;
      6'd44: c = 7'h5A;
      6'd45: c = 7'h58;
      6'd46: c = 7'h43;
      6'd47: c = 7'h56;
      6'd48: c = 7'h42;
      6'd49: c = 7'h4E;
      6'd50: c = 7'h4D;
      6'd51: c = 7'h3C;
      6'd52: c = 7'h3E;
      6'd53: c = 7'h3F;
      6'd55: c = 7'h2A;
      6'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/sc2a_decode.sv
// ---------------------------------------------------------------------------
// sc2a_decode: set-1 scan byte decoder
// Tracks prefix, shift and caps lock, and maps a press to its character.
// ---------------------------------------------------------------------------
module sc2a_decode (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [7:0] scan_byte,
  output logic [6:0] char_code
);
  import sc2a_pkg::*;

  logic shift_held, shift_held_next;
  logic caps_locked, caps_locked_next;
  logic prefix_pending, prefix_pending_next;
  logic [6:0] mapped;

  // Flag updates and character lookup
  always_comb begin
    shift_held_next     = shift_held;
    caps_locked_next    = caps_locked;
    prefix_pending_next = prefix_pending;
    mapped              = 7'h00;
    char_code           = 7'h00;
    priority if (scan_byte == SC_PREFIX) begin
      prefix_pending_next = 1'b1;
    end else if (prefix_pending) begin
      prefix_pending_next = 1'b0;
    end else if (scan_byte[7]) begin
      if (scan_byte == SC_LSHIFT_REL || scan_byte == SC_RSHIFT_REL) begin
        shift_held_next = 1'b0;
      end
    end else begin
      if (scan_byte == SC_LSHIFT || scan_byte == SC_RSHIFT) begin
        shift_held_next = 1'b1;
      end
      if (scan_byte == SC_CAPS) begin
        caps_locked_next = !caps_locked;
      end
      if (scan_byte < MAP_LEN) begin
        mapped = shift_held_next ? shifted_map(scan_byte[5:0]) : plain_map(scan_byte[5:0]);
      end
      // caps lock swaps letter case
      if (caps_locked_next && mapped >= 7'h61 && mapped <= 7'h7A) begin
        char_code = mapped - CASE_OFFSET;
      end else if (caps_locked_next && mapped >= 7'h41 && mapped <= 7'h5A) begin
        char_code = mapped + CASE_OFFSET;
      end else begin
        char_code = mapped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held     <= 1'b0;
      caps_locked    <= 1'b0;
      prefix_pending <= 1'b0;
    end else if (en) begin
      shift_held     <= shift_held_next;
      caps_locked    <= caps_locked_next;
      prefix_pending <= prefix_pending_next;
    end
  end

endmodule

// File: rtl/core/sc2a_queue.sv
// ---------------------------------------------------------------------------
// sc2a_queue: character ring queue
// Synchronous store with read and write pointers; one slot kept empty.
// ---------------------------------------------------------------------------
module sc2a_queue (
  input  logic              clk,
  input  logic              rst,
  input  sc2a_pkg::q_ctrl_t ctrl,
  output sc2a_pkg::q_stat_t stat,
  output logic [6:0]        rd_char
);
  import sc2a_pkg::*;

  localparam logic [PTR_W-1:0] LAST = PTR_W'(QSLOTS - 1);

  logic [6:0]       char_store [QSLOTS];
  logic [PTR_W-1:0] read_pointer, write_pointer;
  logic [PTR_W-1:0] rd_adv, wr_adv;

  // Pointer wrap
  assign rd_adv = (read_pointer == LAST) ? '0 : read_pointer + PTR_W'(1);
  assign wr_adv = (write_pointer == LAST) ? '0 : write_pointer + PTR_W'(1);

  assign stat.full  = (wr_adv == read_pointer);
  assign stat.empty = (read_pointer == write_pointer);

  // Store: one write and one read per cycle, read data registered
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      char_store[write_pointer] <= ctrl.wr_char;
    end
    if (ctrl.pop) begin
      rd_char <= char_store[read_pointer];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer  <= '0;
      write_pointer <= '0;
    end else begin
      if (ctrl.push) begin
        write_pointer <= wr_adv;
      end
      if (ctrl.pop) begin
        read_pointer <= rd_adv;
      end
    end
  end

endmodule

// File: rtl/core/sc2a_out_fifo.sv
// ---------------------------------------------------------------------------
// sc2a_out_fifo: two-word result buffer
// Decouples the result side so input words keep flowing under a stall.
// ---------------------------------------------------------------------------
module sc2a_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sc2a_pkg::rsp_word_t push_word,
  input  logic                pop,
  output logic                valid,
  output sc2a_pkg::rsp_word_t word,
  output logic [1:0]          count
);
  import sc2a_pkg::*;

  rsp_word_t slots [2];
  logic      wr_ptr, rd_ptr;

  assign valid = (count != 2'd0);
  assign word  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/scan_code_to_ascii_queue_core.sv
// ---------------------------------------------------------------------------
// scan_code_to_ascii_queue_core: keyboard scan decoder with character queue
// Decodes set-1 scan bytes into ASCII and queues them; read words pop one.
//
//   channel | direction | handshake           | word
//   req     | in        | req_valid/req_stall | opcode, scan_byte
//   rsp     | out       | rsp_valid/rsp_stall | status, char_code
//
// One word per cycle sustained while rsp_stall is low; results pass through stage 1 and the output buffer.
// The popped character is registered out of the store and joins stage 1 in the cycle after a read word is accepted.
// Two result words can be buffered, so input is held off only when both wait.
// Synchronous reset clears flags and pointers; the store is not cleared.
// ---------------------------------------------------------------------------
module scan_code_to_ascii_queue_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  sc2a_pkg::req_word_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output sc2a_pkg::rsp_word_t rsp
);
  import sc2a_pkg::*;

  logic       req_acc, rsp_acc;
  logic       scan_acc, read_acc;
  logic [6:0] dec_char;
  q_ctrl_t    q_ctrl;
  q_stat_t    q_stat;
  logic [6:0] rd_char;

  logic       s1_valid;
  logic       s1_pop;
  logic [2:0] s1_status;
  logic [6:0] s1_char;
  rsp_word_t  s1_word;
  logic [1:0] fifo_count;
  logic [1:0] occupancy;

  // Handshake: room for one more word unless two are held and none leaves
  assign occupancy = fifo_count + {1'b0, s1_valid};
  assign rsp_acc   = rsp_valid && !rsp_stall;
  assign req_stall = (occupancy == 2'd2) && !rsp_acc;
  assign req_acc   = req_valid && !req_stall;
  assign scan_acc  = req_acc && (req.opcode == OP_SCAN);
  assign read_acc  = req_acc && (req.opcode == OP_READ);

  sc2a_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .en        (scan_acc),
    .scan_byte (req.scan_byte),
    .char_code (dec_char)
  );

  // Queue requests
  assign q_ctrl.push    = scan_acc && (dec_char != 7'h00) && !q_stat.full;
  assign q_ctrl.pop     = read_acc && !q_stat.empty;
  assign q_ctrl.wr_char = dec_char;

  sc2a_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (q_ctrl),
    .stat    (q_stat),
    .rd_char (rd_char)
  );

  // Stage 1: status and character, popped character joins from the store
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= req_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      s1_pop <= q_ctrl.pop;
      if (req.opcode == OP_READ) begin
        s1_status <= q_stat.empty ? ST_EMPTY : ST_READ;
        s1_char   <= 7'h00;
      end else if (dec_char == 7'h00) begin
        s1_status <= ST_NONE;
        s1_char   <= 7'h00;
      end else begin
        s1_status <= q_stat.full ? ST_DROPPED : ST_QUEUED;
        s1_char   <= dec_char;
      end
    end
  end

  assign s1_word.status    = s1_status;
  assign s1_word.char_code = s1_pop ? rd_char : s1_char;

  sc2a_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_word (s1_word),
    .pop       (rsp_acc),
    .valid     (rsp_valid),
    .word      (rsp),
    .count     (fifo_count)
  );

`ifndef SYNTH
  // Output buffer never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (fifo_count != 2'd2) || rsp_acc)
    else $error("result buffer overflow");

  // No push into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_ctrl.push |-> !q_stat.full)
    else $error("push into full queue");

  // A read of a non-empty queue takes the character from the store
  a_pop_path: assert property (@(posedge clk) disable iff (rst)
    read_acc && !q_stat.empty |=> s1_valid && s1_pop && (s1_status == ST_READ))
    else $error("popped character not routed from store");
`endif

endmodule

// File: test/scan_code_to_ascii_queue_core_test.sv
// ---------------------------------------------------------------------------
// scan_code_to_ascii_queue_core_test: self-checking bench for the key decoder
// Feeds scan bytes and read words through the request channel, predicts each
// result word from a behavioural copy of the decoder and its character queue,
// and checks every result word in order. Both sides idle and stall at random;
// a long receiver hold-off fills the block and a sender pause drains it.
// ---------------------------------------------------------------------------
module scan_code_to_ascii_queue_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sc2a_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    req_word_t word;
    bit        drain;   // wait for every result before sending this word
  } key_event_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_word_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_word_t rsp;

  scan_code_to_ascii_queue_core uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #10 clk = ~clk;

  // Set-1 key maps, indexed by make code
  logic [6:0] plain_keys [0:57] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h00, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };
  logic [6:0] shifted_keys [0:57] = '{
    7'h00, 7'h01, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  // Decoder state as the bench sees it
  bit         shift_held;
  bit         caps_locked;
  bit         prefix_pending;
  logic [6:0] typed_chars [$];

  key_event_t key_events [$];
  rsp_word_t  due_results [$];
  key_event_t next_event;
  rsp_word_t  want;
  bit         req_fire;
  int         cycle_count;
  int         accepted;
  int         mismatches;
  int         hold_left;
  int         next_hold_at = 130;
  bit         calm;

  // One word in, one result word out; updates flags and the character queue
  function automatic rsp_word_t decode_key_word(input req_word_t w);
    rsp_word_t  r;
    logic [6:0] ch;
    r  = '0;
    ch = '0;
    if (w.opcode == OP_READ) begin
      if (typed_chars.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status    = ST_READ;
        r.char_code = typed_chars.pop_front();
      end
    end else begin
      if (w.scan_byte == SC_PREFIX) begin
        prefix_pending = 1'b1;
      end else if (prefix_pending) begin
        prefix_pending = 1'b0;
      end else if (w.scan_byte[7]) begin
        // break codes only matter for the shift keys
        if (w.scan_byte == SC_LSHIFT_REL || w.scan_byte == SC_RSHIFT_REL) begin
          shift_held = 1'b0;
        end
      end else begin
        if (w.scan_byte == SC_LSHIFT || w.scan_byte == SC_RSHIFT) begin
          shift_held = 1'b1;
        end
        if (w.scan_byte == SC_CAPS) begin
          caps_locked = !caps_locked;
        end
        if (w.scan_byte < MAP_LEN) begin
          ch = shift_held ? shifted_keys[w.scan_byte[5:0]] : plain_keys[w.scan_byte[5:0]];
        end
        // caps lock swaps letter case only
        if (caps_locked && ch >= 7'h61 && ch <= 7'h7A) begin
          ch = ch - CASE_OFFSET;
        end else if (caps_locked && ch >= 7'h41 && ch <= 7'h5A) begin
          ch = ch + CASE_OFFSET;
        end
      end
      if (ch == '0) begin
        r.status = ST_NONE;
      end else if (typed_chars.size() == QSLOTS - 1) begin
        r.status    = ST_DROPPED;
        r.char_code = ch;
      end else begin
        typed_chars.push_back(ch);
        r.status    = ST_QUEUED;
        r.char_code = ch;
      end
    end
    return r;
  endfunction

  task automatic report(input string what, input rsp_word_t exp_w, input rsp_word_t got_w);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected status %0d char %h, got status %0d char %h", $time, what,
               exp_w.status, exp_w.char_code, got_w.status, got_w.char_code);
    end
  endtask

  task automatic add_word(input logic op, input logic [7:0] code, input bit drain);
    key_event_t e;
    e.word.opcode    = op;
    e.word.scan_byte = code;
    e.drain          = drain;
    key_events.push_back(e);
  endtask

  // Make code that yields a character whatever the shift and caps lock state
  function automatic logic [7:0] typing_code();
    case ($urandom_range(3))
      0:       return 8'($urandom_range(8'h02, 8'h0E));
      1:       return 8'($urandom_range(8'h10, 8'h1C));
      2:       return 8'($urandom_range(8'h1E, 8'h29));
      default: return 8'($urandom_range(8'h2B, 8'h35));
    endcase
  endfunction

  function automatic logic [7:0] modifier_code();
    case ($urandom_range(6))
      0:       return SC_LSHIFT;
      1:       return SC_RSHIFT;
      2:       return SC_LSHIFT_REL;
      3:       return SC_RSHIFT_REL;
      4:       return SC_CAPS;
      5:       return SC_PREFIX;
      default: return 8'h80 | typing_code();
    endcase
  endfunction

  // Mixed traffic: reads, raw bytes, modifiers and typing
  task automatic add_mixed(input int count, input int read_pct);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < read_pct) begin
        add_word(OP_READ, 8'($urandom_range(255)), i == 0);
      end else if (roll < read_pct + 12) begin
        add_word(OP_SCAN, 8'($urandom_range(255)), i == 0);
      end else if (roll < read_pct + 24) begin
        add_word(OP_SCAN, modifier_code(), i == 0);
      end else begin
        add_word(OP_SCAN, typing_code(), i == 0);
      end
    end
  endtask

  // Accept, predict and check at the rising edge
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    calm        <= (cycle_count >= 300 && cycle_count < 700);
    req_fire = 1'b0;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        req_fire = 1'b1;
        due_results.push_back(decode_key_word(req));
        accepted++;
      end
      if (rsp_valid && !rsp_stall) begin
        if (due_results.size() == 0) begin
          report("unexpected word", '0, rsp);
        end else begin
          want = due_results.pop_front();
          if (rsp.status !== want.status) begin
            report("status", want, rsp);
          end else if (rsp.char_code !== want.char_code) begin
            report("char_code", want, rsp);
          end
        end
      end
    end
  end

  // Sender: next word at the falling edge once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fire) begin
      if (key_events.size() != 0 && !(key_events[0].drain && due_results.size() != 0) &&
          (calm || hold_left != 0 || $urandom_range(99) >= 24)) begin
        next_event = key_events.pop_front();
        req       <= next_event.word;
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus long hold-offs to back the block up
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else if (accepted >= next_hold_at) begin
      next_hold_at <= next_hold_at + 400;
      hold_left    <= HOLD_CYCLES;
      rsp_stall    <= 1'b1;
    end else begin
      rsp_stall <= !calm && ($urandom_range(99) < 24);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int roll;
    // Directed: empty read, shifted control keys, caps, breaks, prefixes
    add_word(OP_READ, 8'h00, 1'b0);
    add_word(OP_SCAN, 8'h1E, 1'b0);
    add_word(OP_SCAN, SC_LSHIFT, 1'b0);
    add_word(OP_SCAN, 8'h01, 1'b0);
    add_word(OP_SCAN, 8'h0F, 1'b0);
    add_word(OP_SCAN, 8'h10, 1'b0);
    add_word(OP_SCAN, SC_LSHIFT_REL, 1'b0);
    add_word(OP_SCAN, SC_CAPS, 1'b0);
    add_word(OP_SCAN, 8'h2C, 1'b0);
    add_word(OP_SCAN, SC_RSHIFT, 1'b0);
    add_word(OP_SCAN, 8'h2C, 1'b0);
    add_word(OP_SCAN, 8'h02, 1'b0);
    add_word(OP_SCAN, SC_RSHIFT_REL, 1'b0);
    add_word(OP_SCAN, 8'h9E, 1'b0);
    add_word(OP_SCAN, SC_PREFIX, 1'b0);
    add_word(OP_SCAN, SC_PREFIX, 1'b0);
    add_word(OP_SCAN, 8'h1E, 1'b0);
    add_word(OP_SCAN, SC_PREFIX, 1'b0);
    add_word(OP_SCAN, SC_LSHIFT, 1'b0);
    add_word(OP_SCAN, 8'h7F, 1'b0);
    add_word(OP_SCAN, SC_CAPS, 1'b0);
    add_word(OP_SCAN, 8'h00, 1'b0);
    add_word(OP_SCAN, 8'hFF, 1'b0);
    add_word(OP_SCAN, 8'h39, 1'b0);
    add_word(OP_READ, 8'hFF, 1'b0);

    // Typing with no reads: fills the queue, wraps the write side, then drops
    for (int i = 0; i < 530; i++) begin
      roll = $urandom_range(99);
      if (roll < 2) begin
        add_word(OP_SCAN, modifier_code(), 1'b0);
      end else begin
        add_word(OP_SCAN, typing_code(), 1'b0);
      end
    end

    // Read-heavy tail, sent only once everything before it has drained
    add_mixed(20, 50);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (key_events.size() != 0 || req_valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/sc2a_pkg.sv
rtl/core/sc2a_decode.sv
rtl/core/sc2a_queue.sv
rtl/core/sc2a_out_fifo.sv
rtl/core/scan_code_to_ascii_queue_core.sv
test/scan_code_to_ascii_queue_core_test.sv
